// ===== src/tlpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-level priority buffer package
// Shared types, codes and default settings for the two-level priority buffer.
// ----------------------------------------------------------------------------
package tlpb_pkg;

    localparam int DEFAULT_MAX_DEPTH = 16;

    localparam int VALUE_W = 16;
    localparam int STAMP_W = 32;
    localparam int ENTRY_W = VALUE_W + STAMP_W;
    localparam int COUNT_W = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;
    localparam logic [VALUE_W-1:0] POISON_RESET   = 16'hFFFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POISON   = 1'b1;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
    } dp_cmd_t;

endpackage

// ===== src/tlpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Two-level priority buffer controller
// Sequences each transfer: take one item, then present its result until taken.
// ----------------------------------------------------------------------------
module tlpb_ctrl
    import tlpb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.exec = s_valid;
                if (s_valid) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/tlpb_datapath.sv =====
// ----------------------------------------------------------------------------
// Two-level priority buffer datapath
// Configuration registers, the urgent and normal rings and the result registers.
// ----------------------------------------------------------------------------
module tlpb_datapath
    import tlpb_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  dp_cmd_t                    cmd,
    input  logic                       in_command,
    input  logic signed [VALUE_W-1:0]  in_value,
    input  logic                       in_urgent,
    input  logic [STAMP_W-1:0]         in_stamp,
    output logic [1:0]                 out_status,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic                       out_urgent,
    output logic [STAMP_W-1:0]         out_stamp,
    output logic [COUNT_W-1:0]         out_occupancy
);

    localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CMP_W = (PTR_W + 1 > COUNT_W) ? PTR_W + 1 : COUNT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(MAX_DEPTH);

    logic [COUNT_W-1:0]        capacity_reg;
    logic signed [VALUE_W-1:0] poison_reg;

    logic [ENTRY_W-1:0] urgent_mem [MAX_DEPTH];
    logic [ENTRY_W-1:0] normal_mem [MAX_DEPTH];
    logic [ENTRY_W-1:0] urgent_rd_reg;
    logic [ENTRY_W-1:0] normal_rd_reg;

    logic [PTR_W-1:0]   urgent_head_reg, urgent_head_next;
    logic [PTR_W-1:0]   urgent_tail_reg, urgent_tail_next;
    logic [PTR_W-1:0]   normal_head_reg, normal_head_next;
    logic [PTR_W-1:0]   normal_tail_reg, normal_tail_next;
    logic [COUNT_W-1:0] urgent_held_reg, urgent_held_next;
    logic [COUNT_W-1:0] normal_held_reg, normal_held_next;
    logic [COUNT_W-1:0] total_held_reg, total_held_next;

    status_t status_reg, status_next;
    logic    returned_reg, returned_next;
    logic    from_urgent_reg, from_urgent_next;

    logic [CMP_W-1:0] cap_floor;
    logic [CMP_W-1:0] eff_cap;
    logic             is_full;
    logic             is_empty;
    logic             put_urgent;
    logic             wr_urgent;
    logic             wr_normal;
    logic             rd_urgent;
    logic             rd_normal;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CMP_W-1:0] cap);
        logic [CMP_W-1:0] n;
        n = CMP_W'(p) + CMP_W'(1);
        return (n >= cap) ? '0 : n[PTR_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            poison_reg   <= POISON_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_CAPACITY: capacity_reg <= cfg_wr_data[COUNT_W-1:0];
                CFG_POISON:   poison_reg   <= cfg_wr_data;
                default:      ;
            endcase
        end
    end

    always_comb begin
        cap_floor = (capacity_reg == '0) ? CMP_W'(1) : CMP_W'(capacity_reg);
        eff_cap   = (cap_floor > DEPTH_C) ? DEPTH_C : cap_floor;
        is_full   = CMP_W'(total_held_reg) >= eff_cap;
        is_empty  = (total_held_reg == '0);
        put_urgent = in_urgent && (in_value != poison_reg);
        wr_urgent = cmd.exec && (in_command == CMD_PUT) && !is_full && put_urgent;
        wr_normal = cmd.exec && (in_command == CMD_PUT) && !is_full && !put_urgent;
        rd_urgent = cmd.exec && (in_command == CMD_GET) && !is_empty
                    && (urgent_held_reg != '0);
        rd_normal = cmd.exec && (in_command == CMD_GET) && !is_empty
                    && (urgent_held_reg == '0);
    end

    always_comb begin
        urgent_head_next = urgent_head_reg;
        urgent_tail_next = urgent_tail_reg;
        normal_head_next = normal_head_reg;
        normal_tail_next = normal_tail_reg;
        urgent_held_next = urgent_held_reg;
        normal_held_next = normal_held_reg;
        total_held_next  = total_held_reg;
        status_next      = status_reg;
        returned_next    = returned_reg;
        from_urgent_next = from_urgent_reg;
        if (cmd.exec) begin
            status_next      = ST_DONE;
            returned_next    = rd_urgent || rd_normal;
            from_urgent_next = rd_urgent;
            if (in_command == CMD_PUT && is_full) begin
                status_next = ST_FULL;
            end
            if (in_command == CMD_GET && is_empty) begin
                status_next = ST_EMPTY;
            end
        end
        if (wr_urgent) begin
            urgent_tail_next = advance(urgent_tail_reg, eff_cap);
            urgent_held_next = urgent_held_reg + 1'b1;
        end
        if (wr_normal) begin
            normal_tail_next = advance(normal_tail_reg, eff_cap);
            normal_held_next = normal_held_reg + 1'b1;
        end
        if (rd_urgent) begin
            urgent_head_next = advance(urgent_head_reg, eff_cap);
            urgent_held_next = urgent_held_reg - 1'b1;
        end
        if (rd_normal) begin
            normal_head_next = advance(normal_head_reg, eff_cap);
            if (normal_held_reg != '0) begin
                normal_held_next = normal_held_reg - 1'b1;
            end
        end
        if (wr_urgent || wr_normal) begin
            total_held_next = total_held_reg + 1'b1;
        end else if (rd_urgent || rd_normal) begin
            total_held_next = total_held_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            urgent_head_reg <= '0;
            urgent_tail_reg <= '0;
            normal_head_reg <= '0;
            normal_tail_reg <= '0;
            urgent_held_reg <= '0;
            normal_held_reg <= '0;
            total_held_reg  <= '0;
        end else begin
            urgent_head_reg <= urgent_head_next;
            urgent_tail_reg <= urgent_tail_next;
            normal_head_reg <= normal_head_next;
            normal_tail_reg <= normal_tail_next;
            urgent_held_reg <= urgent_held_next;
            normal_held_reg <= normal_held_next;
            total_held_reg  <= total_held_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg      <= status_next;
        returned_reg    <= returned_next;
        from_urgent_reg <= from_urgent_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_urgent) begin
            urgent_mem[urgent_tail_reg] <= {in_value, in_stamp};
        end
        if (rd_urgent) begin
            urgent_rd_reg <= urgent_mem[urgent_head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_normal) begin
            normal_mem[normal_tail_reg] <= {in_value, in_stamp};
        end
        if (rd_normal) begin
            normal_rd_reg <= normal_mem[normal_head_reg];
        end
    end

    always_comb begin
        out_status    = status_reg;
        out_occupancy = total_held_reg;
        out_urgent    = returned_reg && from_urgent_reg;
        out_value     = '0;
        out_stamp     = '0;
        if (returned_reg) begin
            if (from_urgent_reg) begin
                out_value = urgent_rd_reg[ENTRY_W-1:STAMP_W];
                out_stamp = urgent_rd_reg[STAMP_W-1:0];
            end else begin
                out_value = normal_rd_reg[ENTRY_W-1:STAMP_W];
                out_stamp = normal_rd_reg[STAMP_W-1:0];
            end
        end
    end

endmodule

// ===== src/two_level_priority_buffer_top.sv =====
// ----------------------------------------------------------------------------
// Two-level priority buffer
// Urgent and normal ring buffers sharing one capacity, with strict priority.
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel is a put (s_command low) or a get (high).
// A put stores s_value and s_stamp in the urgent ring when s_urgent is set
// and the value differs from the poison register, otherwise in the normal
// ring. A get returns the oldest urgent item, else the oldest normal item.
// Every input transfer yields exactly one result transfer on the m_ channel,
// carrying a status (done, full or empty) and the occupancy after the step.
// The configuration port writes capacity (index 0) and poison value
// (index 1); it is to be used only while the block is idle, and the
// block itself does not enforce this. An item is taken in the idle state
// and its result is shown from the next cycle, in the response state; no
// new item is taken until that result has been taken. While m_valid waits for
// m_ready the result is held and s_ready stays low. Reset empties both
// rings at once and restores capacity 16 and poison value -1.
// ----------------------------------------------------------------------------
module two_level_priority_buffer_top
    import tlpb_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic signed [VALUE_W-1:0]  s_value,
    input  logic                       s_urgent,
    input  logic [STAMP_W-1:0]         s_stamp,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic signed [VALUE_W-1:0]  m_out_value,
    output logic                       m_out_urgent,
    output logic [STAMP_W-1:0]         m_out_stamp,
    output logic [COUNT_W-1:0]         m_occupancy
);

    dp_cmd_t cmd;

    tlpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tlpb_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .in_command    (s_command),
        .in_value      (s_value),
        .in_urgent     (s_urgent),
        .in_stamp      (s_stamp),
        .out_status    (m_status),
        .out_value     (m_out_value),
        .out_urgent    (m_out_urgent),
        .out_stamp     (m_out_stamp),
        .out_occupancy (m_occupancy)
    );

endmodule

// ===== src/tlpb_checker.sv =====
// ----------------------------------------------------------------------------
// Two-level priority buffer checker
// Port-level checks on the results of the two-level priority buffer.
// ----------------------------------------------------------------------------
module tlpb_checker
    import tlpb_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [1:0]                m_status,
    input logic signed [VALUE_W-1:0] m_out_value,
    input logic                      m_out_urgent,
    input logic [STAMP_W-1:0]        m_out_stamp,
    input logic [COUNT_W-1:0]        m_occupancy
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input taken while a result is pending.");

    a_no_payload_unless_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DONE) |->
            (m_out_value == '0 && m_out_stamp == '0 && !m_out_urgent))
        else $error("Rejected result carries a payload.");

    a_empty_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> (m_occupancy == '0))
        else $error("Empty status with items held.");

    a_occupancy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy <= COUNT_W'(16)))
        else $error("Occupancy above the largest capacity.");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
                                    && $stable(m_occupancy)))
        else $error("Stalled result changed.");

endmodule

bind two_level_priority_buffer_top tlpb_checker u_tlpb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_out_value  (m_out_value),
    .m_out_urgent (m_out_urgent),
    .m_out_stamp  (m_out_stamp),
    .m_occupancy  (m_occupancy)
);
